FILE: design/eira_pkg.sv
package eira_pkg;
  localparam int unsigned MaxCodewordDef  = 65536;
  localparam int unsigned MaxRowsDef      = 32768;
  localparam int unsigned MaxRowWeightDef = 32;
  localparam int unsigned MaxBlockDef     = 128;

  typedef enum logic [2:0] {
    CmdLoadMsg = 3'd0,
    CmdLoadRow = 3'd1,
    CmdLoadP   = 3'd2,
    CmdEncode  = 3'd3,
    CmdRead    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CfgDataLen   = 2'd0,
    CfgParityLen = 2'd1,
    CfgRowSlots  = 2'd2,
    CfgBlockSize = 2'd3
  } cfg_idx_e;
endpackage

FILE: design/eira_ram.sv
module eira_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/eira_ldpc_encoder_core.sv
// eIRA LDPC encoder core.
// Input channel (in_valid_i / in_stall_o) carries one command beat: load message
// bit, load row entry, load P bit, encode, or read codeword bit. Every command
// returns exactly one result beat (read_bit_o, status_o) on the output channel
// (out_valid_o / out_stall_i). Config writes (cfg_valid_i/cfg_ready_o) set k, m,
// row slots and block size z; write only while idle.
// One command is in flight at a time. A load, or a rejected command, goes through
// StExec to its result beat; a read goes through StExec and then StRdWait. The next
// command is taken the cycle after the result beat leaves. An encode first clears
// the parity bits and the block memory, then walks each row, doing per slot a
// row-table read, a codeword read and an accumulate. Block mode walks the m rows
// for syndromes, then forms the P product (read P and syndrome, accumulate; write
// a parity bit per row of P), then walks the remaining m-z rows.
// Reset clears control state; the stores hold garbage until written and the
// syndrome/accumulator memory is cleared during each encode's clear pass.
// While the result waits under stall no new command is taken.
module eira_ldpc_encoder_core #(
  parameter int unsigned MaxCodeword  = eira_pkg::MaxCodewordDef,
  parameter int unsigned MaxRows      = eira_pkg::MaxRowsDef,
  parameter int unsigned MaxRowWeight = eira_pkg::MaxRowWeightDef,
  parameter int unsigned MaxBlock     = eira_pkg::MaxBlockDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] index_i,
  input  logic [6:0]  slot_i,
  input  logic [16:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        read_bit_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import eira_pkg::*;

  localparam int unsigned CwAw = $clog2(MaxCodeword);
  localparam int unsigned RwW  = $clog2(MaxRowWeight);
  localparam int unsigned RtAw = $clog2(MaxRows) + RwW;
  localparam int unsigned BlW  = $clog2(MaxBlock);
  localparam int unsigned PAw  = 2 * BlW;

  typedef enum logic [12:0] {
    StIdle   = 13'b0000000000001,
    StExec   = 13'b0000000000010,
    StRdWait = 13'b0000000000100,
    StClear  = 13'b0000000001000,
    StRowBeg = 13'b0000000010000,
    StSlotRd = 13'b0000000100000,
    StSlotCw = 13'b0000001000000,
    StSlotAc = 13'b0000010000000,
    StRowEnd = 13'b0000100000000,
    StPRd    = 13'b0001000000000,
    StPAcc   = 13'b0010000000000,
    StPWr    = 13'b0100000000000,
    StResp   = 13'b1000000000000
  } state_e;

  // encode pass (one-hot): plain, syndrome, block accumulate
  typedef enum logic [2:0] {
    PassPlain = 3'b001,
    PassSynd  = 3'b010,
    PassAcc   = 3'b100
  } pass_e;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;

  logic [15:0] k_q, m_q;
  logic [5:0]  slots_q;
  logic [7:0]  z_q;

  logic [2:0]  cmd_q;
  logic [15:0] idx_q;
  logic [6:0]  slot_q;
  logic [16:0] val_q;
  logic        rbit_q, rbit_d, stat_q, stat_d;

  logic [16:0] eff_k, eff_m, room, nlen;
  logic [6:0]  eff_w;
  logic [16:0] limit_q;

  logic [16:0] row_q, row_d;     // row counter (also clear counter)
  logic [6:0]  sl_q, sl_d;
  logic [16:0] col_q, col_d;
  logic        acc_q, acc_d, rp_q, rp_d;
  logic [7:0]  pos_q, pos_d;     // row mod z
  logic [7:0]  pr_q, pr_d, pc_q, pc_d;

  // memories
  logic            cw_we, cw_wd, cw_rd;
  logic [CwAw-1:0] cw_wa, cw_ra;
  logic            rt_we;
  logic [RtAw-1:0] rt_wa, rt_ra;
  logic [16:0]     rt_rd;
  logic            p_we, p_rd;
  logic [PAw-1:0]  p_wa, p_ra;
  // block memory: bit 0 syndrome, bit 1 accumulator
  logic            bk_we;
  logic [BlW-1:0]  bk_wa, bk_ra;
  logic [1:0]      bk_wd, bk_rd;

  eira_ram #(.Width(1), .Depth(MaxCodeword)) u_cw (
    .clk_i, .we_i(cw_we), .waddr_i(cw_wa), .wdata_i(cw_wd),
    .raddr_i(cw_ra), .rdata_o(cw_rd));
  eira_ram #(.Width(17), .Depth(MaxRows * MaxRowWeight)) u_rt (
    .clk_i, .we_i(rt_we), .waddr_i(rt_wa), .wdata_i(val_q),
    .raddr_i(rt_ra), .rdata_o(rt_rd));
  eira_ram #(.Width(1), .Depth(MaxBlock * MaxBlock)) u_p (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(val_q[0]),
    .raddr_i(p_ra), .rdata_o(p_rd));
  eira_ram #(.Width(2), .Depth(MaxBlock)) u_bk (
    .clk_i, .we_i(bk_we), .waddr_i(bk_wa), .wdata_i(bk_wd),
    .raddr_i(bk_ra), .rdata_o(bk_rd));

  always_comb begin
    eff_k = ({1'b0, k_q} < 17'(MaxCodeword)) ? {1'b0, k_q} : 17'(MaxCodeword);
    room  = 17'(MaxCodeword) - eff_k;
    eff_m = {1'b0, m_q};
    if (eff_m > 17'(MaxRows)) eff_m = 17'(MaxRows);
    if (eff_m > room) eff_m = room;
    nlen  = eff_k + eff_m;
    eff_w = ({1'b0, slots_q} < 7'(MaxRowWeight)) ? {1'b0, slots_q} : 7'(MaxRowWeight);
  end

  // limit_q steps up by z during the clear pass to reach (k / z) * z
  logic [16:0] limit_d;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StResp);
  assign read_bit_o  = rbit_q;
  assign status_o    = stat_q;

  logic [16:0] kz_row;
  logic        in_lim;
  logic [16:0] mz;
  assign kz_row = eff_k + row_q;
  assign mz     = eff_m - {9'd0, z_q};
  assign in_lim = (pass_q == PassSynd) ? (col_q <= limit_q) : 1'b1;

  always_comb begin
    state_d = state_q; pass_d = pass_q;
    rbit_d = rbit_q; stat_d = stat_q;
    row_d = row_q; sl_d = sl_q; col_d = col_q; acc_d = acc_q; rp_d = rp_q;
    pos_d = pos_q; pr_d = pr_q; pc_d = pc_q; limit_d = limit_q;
    cw_we = 1'b0; cw_wd = 1'b0; cw_wa = '0; cw_ra = '0;
    rt_we = 1'b0; rt_wa = '0; rt_ra = '0;
    p_we = 1'b0; p_wa = '0; p_ra = '0;
    bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = BlW'(pos_q);
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        rbit_d = 1'b0; stat_d = 1'b0; state_d = StResp;
        case (cmd_q)
          CmdLoadMsg: begin
            if ({1'b0, idx_q} < eff_k) begin
              cw_we = 1'b1; cw_wa = CwAw'(idx_q); cw_wd = val_q[0];
            end else stat_d = 1'b1;
          end
          CmdLoadRow: begin
            if (32'(idx_q) < MaxRows && 32'(slot_q) < MaxRowWeight) begin
              rt_we = 1'b1;
              rt_wa = RtAw'({idx_q, {RwW{1'b0}}}) | RtAw'(slot_q);
            end else stat_d = 1'b1;
          end
          CmdLoadP: begin
            if (32'(idx_q) < MaxBlock && 32'(slot_q) < MaxBlock) begin
              p_we = 1'b1;
              p_wa = {BlW'(idx_q), BlW'(slot_q)};
            end else stat_d = 1'b1;
          end
          CmdEncode: begin
            if (32'(z_q) > MaxBlock || {9'd0, z_q} > eff_m) stat_d = 1'b1;
            else begin
              state_d = StClear; row_d = '0; limit_d = '0; rp_d = 1'b0;
              pass_d = (z_q == 8'd0) ? PassPlain : PassSynd;
            end
          end
          CmdRead: begin
            if ({1'b0, idx_q} < nlen) begin
              cw_ra = CwAw'(idx_q); state_d = StRdWait;
            end else stat_d = 1'b1;
          end
          default: stat_d = 1'b1;
        endcase
      end
      StRdWait: begin
        rbit_d = cw_rd; state_d = StResp;
      end
      StClear: begin
        if (z_q != 8'd0 && limit_q + {9'd0, z_q} <= eff_k)
          limit_d = limit_q + {9'd0, z_q};
        if (row_q < eff_m) begin
          cw_we = 1'b1; cw_wa = CwAw'(kz_row); cw_wd = 1'b0;
          bk_we = 1'b1; bk_wa = BlW'(row_q); bk_wd = 2'b00;
          row_d = row_q + 17'd1;
        end else if (z_q == 8'd0 || limit_q + {9'd0, z_q} > eff_k) begin
          row_d = '0; pos_d = '0; state_d = StRowBeg;
        end
      end
      StRowBeg: begin
        sl_d = '0; acc_d = 1'b0;
        if (row_q >= ((pass_q == PassAcc) ? mz : eff_m)) begin
          if (pass_q == PassSynd) begin
            pr_d = '0; pc_d = '0; acc_d = 1'b0; state_d = StPRd;
          end else state_d = StResp;
        end else if (eff_w == 7'd0) state_d = StRowEnd;
        else state_d = StSlotRd;
      end
      StSlotRd: begin
        rt_ra = RtAw'({row_q[15:0], {RwW{1'b0}}}) | RtAw'(sl_q);
        state_d = StSlotCw;
      end
      StSlotCw: begin
        col_d = rt_rd;
        cw_ra = CwAw'(rt_rd - 17'd1);
        state_d = StSlotAc;
      end
      StSlotAc: begin
        if (col_q != 17'd0 && col_q <= nlen && in_lim) acc_d = acc_q ^ cw_rd;
        sl_d = sl_q + 7'd1;
        state_d = (sl_q + 7'd1 >= eff_w) ? StRowEnd : StSlotRd;
      end
      StRowEnd: begin
        case (pass_q)
          PassPlain: begin
            cw_we = 1'b1; cw_wa = CwAw'(kz_row); cw_wd = acc_q ^ rp_q;
            rp_d = acc_q ^ rp_q;
          end
          PassSynd: begin
            bk_we = 1'b1; bk_wa = BlW'(pos_q); bk_wd = {1'b0, bk_rd[0] ^ acc_q};
          end
          default: begin
            cw_we = 1'b1; cw_wa = CwAw'(kz_row + {9'd0, z_q});
            cw_wd = acc_q ^ bk_rd[1];
            bk_we = 1'b1; bk_wa = BlW'(pos_q); bk_wd = {acc_q ^ bk_rd[1], 1'b0};
          end
        endcase
        row_d = row_q + 17'd1;
        pos_d = (pos_q + 8'd1 == z_q) ? 8'd0 : pos_q + 8'd1;
        state_d = StRowBeg;
      end
      StPRd: begin
        p_ra = {BlW'(pr_q), BlW'(pc_q)};
        bk_ra = BlW'(pc_q);
        state_d = StPAcc;
      end
      StPAcc: begin
        acc_d = acc_q ^ (p_rd & bk_rd[0]);
        pc_d = pc_q + 8'd1;
        state_d = (pc_q + 8'd1 == z_q) ? StPWr : StPRd;
      end
      StPWr: begin
        cw_we = 1'b1; cw_wa = CwAw'(eff_k + {9'd0, pr_q}); cw_wd = acc_q;
        acc_d = 1'b0; pc_d = '0; pr_d = pr_q + 8'd1;
        if (pr_q + 8'd1 == z_q) begin
          pass_d = PassAcc; row_d = '0; pos_d = '0; state_d = StRowBeg;
        end else state_d = StPRd;
      end
      StResp: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; pass_q <= PassPlain;
      k_q <= 16'd1; m_q <= 16'd1; slots_q <= 6'd1; z_q <= 8'd0;
      rp_q <= 1'b0;
      rbit_q <= 1'b0; stat_q <= 1'b0;
    end else begin
      state_q <= state_d; pass_q <= pass_d;
      rp_q <= rp_d;
      rbit_q <= rbit_d; stat_q <= stat_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgDataLen:   k_q <= cfg_data_i;
          CfgParityLen: m_q <= cfg_data_i;
          CfgRowSlots:  slots_q <= cfg_data_i[5:0];
          CfgBlockSize: z_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      cmd_q <= command_i; idx_q <= index_i; slot_q <= slot_i; val_q <= value_i;
    end
    row_q <= row_d; sl_q <= sl_d; col_q <= col_d; acc_q <= acc_d;
    pos_q <= pos_d; pr_q <= pr_d; pc_q <= pc_d; limit_q <= limit_d;
  end

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i) |=> state_q == StExec)
    else $error("accepted beat not executed");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(status_o))
    else $error("result dropped under stall");
endmodule
